// ===== sv/fraction_arithmetic_reduce_unit_assert.svh =====
// assertion macros for the fraction unit
`ifndef FRACTION_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH
`define FRACTION_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH

// implication checked every cycle outside reset
`define FAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/far_pkg.sv =====
`default_nettype none
package far_pkg;
  localparam int unsigned InWidth = 16;
  localparam int unsigned ResWidth = 32;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_ADD = 2'd2,
    CMD_SUB = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [InWidth-1:0] num_a;
    logic signed [InWidth-1:0] den_a;
    logic signed [InWidth-1:0] num_b;
    logic signed [InWidth-1:0] den_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [ResWidth-1:0] res_num;
    logic signed [ResWidth-1:0] res_den;
    logic [1:0] status;
  } out_beat_t;

  // datapath operations driven by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SCALE_SET,
    OP_COMBINE,
    OP_RED_SET,
    OP_RED_NUM,
    OP_RED_DEN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_sel;   // which quotient slot receives the divider result
  } dp_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic zero_den;
    logic div_zero;
    logic is_addsub;
    logic res_zero;
    logic g_one;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_GCD1_INIT,
    S_GCD1,
    S_DIV1_INIT,
    S_DIV1,
    S_DIV2_INIT,
    S_DIV2,
    S_SCALE,
    S_COMBINE,
    S_RED_CHECK,
    S_GCD2,
    S_RED_NUM,
    S_RED_DEN,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== sv/fraction_arithmetic_reduce_unit.sv =====
// channel | direction | payload       | handshake
// in      | input     | in_beat_t     | in_valid / in_stall
// out     | output    | out_beat_t    | out_valid / out_stall
// One beat at a time. An error beat goes from S_LOAD straight to S_DONE.
// Mul/div: the multiply and the result gcd, plus two 32-step divides when the
// result is nonzero and its gcd is above 1.
// Add/sub add a denominator gcd, two 32-step divides, S_SCALE and S_COMBINE.
// rst is synchronous active high and clears the controller and out_valid.
// A finished beat waits in the output register while the next input is taken.
`default_nettype none
module fraction_arithmetic_reduce_unit
  import far_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0] st;
  logic [ResWidth-1:0] rn, rd;
  logic [1:0] st_q;
  logic [ResWidth-1:0] rn_q, rd_q;
  logic load_out;

  far_datapath u_dp (
    .clk, .command(in_data.command), .num_a(in_data.num_a), .den_a(in_data.den_a),
    .num_b(in_data.num_b), .den_b(in_data.den_b),
    .cmd, .stat, .res_num(rn), .res_den(rd)
  );

  far_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .status(st), .out_load(load_out)
  );

  // output register: loaded when the controller hands off a beat
  always_ff @(posedge clk) begin
    if (load_out) begin
      st_q <= st;
      rn_q <= (st == ST_OK) ? rn : '0;
      rd_q <= (st == ST_OK) ? rd : '0;
    end
  end

  assign out_data.res_num = rn_q;
  assign out_data.res_den = rd_q;
  assign out_data.status = st_q;

  `include "fraction_arithmetic_reduce_unit_assert.svh"

  `FAR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `FAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
    "output beat changed while stalled")
  `FAR_ASSERT_IMPL(a_status_range, out_valid, out_data.status <= ST_DIV_ZERO, "bad status code")
endmodule
`default_nettype wire

// ===== sv/far_datapath.sv =====
`default_nettype none
module far_datapath
  import far_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [1:0]         command,
  input  wire logic [InWidth-1:0] num_a,
  input  wire logic [InWidth-1:0] den_a,
  input  wire logic [InWidth-1:0] num_b,
  input  wire logic [InWidth-1:0] den_b,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic [ResWidth-1:0]     res_num,
  output logic [ResWidth-1:0]     res_den
);
  localparam int unsigned W = ResWidth;
  localparam int unsigned KW = $clog2(W + 1);
  localparam int unsigned CW = $clog2(W + 1);

  logic [1:0]   op_cmd;
  logic [W-1:0] na, da, nb, db;
  logic [W-1:0] rn, rd;
  logic [W-1:0] ga, gb;
  logic [KW-1:0] gk;
  logic         g_stripped;
  logic [W-1:0] gres;
  logic [W-1:0] dv_rem, dv_quo, dv_den;
  logic [CW-1:0] dv_cnt;
  logic [W-1:0] q0, q1;

  function automatic logic [W-1:0] sext(input logic [InWidth-1:0] v);
    return W'(signed'(v));
  endfunction

  function automatic logic [W-1:0] magf(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  logic [W:0] dv_trial;
  assign dv_trial = {dv_rem, dv_quo[W-1]} - {1'b0, dv_den};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        op_cmd <= command;
        na <= sext(num_a);
        da <= sext(den_a);
        nb <= sext(num_b);
        db <= sext(den_b);
      end
      OP_MUL: begin
        if (op_cmd == CMD_MUL) begin
          rn <= na * nb;
          rd <= da * db;
        end else begin
          rn <= na * db;
          rd <= da * nb;
        end
      end
      OP_GCD_INIT: begin
        ga <= magf(da);
        gb <= magf(db);
        gk <= '0;
        g_stripped <= 1'b0;
      end
      OP_RED_SET: begin
        ga <= magf(rn);
        gb <= magf(rd);
        gk <= '0;
        g_stripped <= 1'b0;
      end
      OP_GCD_STEP: begin
        if (!g_stripped) begin
          if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + KW'(1);
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else begin
            g_stripped <= 1'b1;
          end
        end else if (gb != '0) begin
          if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga > gb) begin
            ga <= gb;
            gb <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
      end
      OP_DIV_INIT: begin
        dv_rem <= '0;
        dv_cnt <= '0;
        dv_den <= gres;
        if (cmd.div_sel) dv_quo <= magf(da);
        else dv_quo <= magf(db);
      end
      OP_DIV_STEP: begin
        if (!dv_trial[W]) dv_rem <= dv_trial[W-1:0];
        else dv_rem <= {dv_rem[W-2:0], dv_quo[W-1]};
        dv_quo <= {dv_quo[W-2:0], ~dv_trial[W]};
        dv_cnt <= dv_cnt + CW'(1);
        if (dv_cnt == CW'(W - 1)) begin
          if (cmd.div_sel) q1 <= {dv_quo[W-2:0], ~dv_trial[W]};
          else q0 <= {dv_quo[W-2:0], ~dv_trial[W]};
        end
      end
      OP_SCALE_SET: begin
        // q0 = |db|/g -> scale a ; q1 = |da|/g -> scale b
        q0 <= da[W-1] ? (~q0 + W'(1)) : q0;
        q1 <= db[W-1] ? (~q1 + W'(1)) : q1;
        rd <= q1 * magf(db);
      end
      OP_COMBINE: begin
        if (op_cmd == CMD_ADD) rn <= na * q0 + nb * q1;
        else rn <= na * q0 - nb * q1;
      end
      OP_RED_NUM: begin
        dv_rem <= '0;
        dv_cnt <= '0;
        dv_den <= gres;
        dv_quo <= magf(rn);
      end
      OP_RED_DEN: begin
        dv_rem <= '0;
        dv_cnt <= '0;
        dv_den <= gres;
        dv_quo <= magf(rd);
      end
      default: ;
    endcase
  end

  // result loaded on OP_RED_SET; reduction quotient signs restored where each divide finishes
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_STEP && dv_cnt == CW'(W - 1) && cmd.div_sel == 1'b0) begin
      res_num <= rn[W-1] ? (~{dv_quo[W-2:0], ~dv_trial[W]} + W'(1))
                         : {dv_quo[W-2:0], ~dv_trial[W]};
    end
    if (cmd.op == OP_DIV_STEP && dv_cnt == CW'(W - 1) && cmd.div_sel == 1'b1) begin
      res_den <= rd[W-1] ? (~{dv_quo[W-2:0], ~dv_trial[W]} + W'(1))
                         : {dv_quo[W-2:0], ~dv_trial[W]};
    end
    if (cmd.op == OP_RED_SET) begin
      res_num <= rn;
      res_den <= rd;
    end
  end

  assign gres = ga << gk;
  assign stat.gcd_done = g_stripped && (gb == '0);
  assign stat.div_done = (dv_cnt == CW'(W - 1));
  assign stat.zero_den = (da == '0) || (db == '0);
  assign stat.div_zero = (op_cmd == CMD_DIV) && (nb == '0);
  assign stat.is_addsub = op_cmd[1];
  assign stat.res_zero = (rn == '0) || (rd == '0);
  assign stat.g_one = (gres == W'(1));
endmodule
`default_nettype wire

// ===== sv/far_ctrl.sv =====
`default_nettype none
module far_ctrl
  import far_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic [1:0]    status,
  output logic          out_load
);
  state_t state, state_next;
  logic [1:0] status_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      status <= ST_OK;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    out_valid_next = out_valid && out_stall;
    out_load = 1'b0;
    cmd.op = OP_NONE;
    cmd.div_sel = 1'b0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.zero_den) begin
          status_next = ST_ZERO_DEN;
          state_next = S_DONE;
        end else if (stat.div_zero) begin
          status_next = ST_DIV_ZERO;
          state_next = S_DONE;
        end else if (stat.is_addsub) begin
          cmd.op = OP_GCD_INIT;
          status_next = ST_OK;
          state_next = S_GCD1;
        end else begin
          cmd.op = OP_MUL;
          status_next = ST_OK;
          state_next = S_RED_CHECK;
        end
      end
      S_GCD1: begin
        if (stat.gcd_done) begin
          cmd.op = OP_DIV_INIT;
          cmd.div_sel = 1'b0;
          state_next = S_DIV1;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      S_DIV1: begin
        cmd.op = OP_DIV_STEP;
        cmd.div_sel = 1'b0;
        if (stat.div_done) state_next = S_DIV2_INIT;
      end
      S_DIV2_INIT: begin
        cmd.op = OP_DIV_INIT;
        cmd.div_sel = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.op = OP_DIV_STEP;
        cmd.div_sel = 1'b1;
        if (stat.div_done) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = OP_SCALE_SET;
        state_next = S_COMBINE;
      end
      S_COMBINE: begin
        cmd.op = OP_COMBINE;
        state_next = S_RED_CHECK;
      end
      S_RED_CHECK: begin
        cmd.op = OP_RED_SET;
        state_next = S_GCD2;
      end
      S_GCD2: begin
        if (stat.res_zero) begin
          state_next = S_DONE;
        end else if (stat.gcd_done) begin
          if (stat.g_one) begin
            state_next = S_DONE;
          end else begin
            cmd.op = OP_RED_NUM;
            state_next = S_RED_NUM;
          end
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      S_RED_NUM: begin
        cmd.op = OP_DIV_STEP;
        cmd.div_sel = 1'b0;
        if (stat.div_done) state_next = S_DIV1_INIT;
      end
      S_DIV1_INIT: begin
        cmd.op = OP_RED_DEN;
        state_next = S_RED_DEN;
      end
      S_RED_DEN: begin
        cmd.op = OP_DIV_STEP;
        cmd.div_sel = 1'b1;
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/fraction_arithmetic_reduce_unit_tb.sv =====
`default_nettype none
module fraction_arithmetic_reduce_unit_tb;
  import far_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  fraction_arithmetic_reduce_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  in_beat_t  op_queue[$];
  out_beat_t expected_q[$];
  int        mismatches = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;
  longint    cycle = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    int k;
    logic [31:0] t;
    k = 0;
    while (((a | b) & 1) == 0) begin
      a >>= 1; b >>= 1; k++;
    end
    while ((a & 1) == 0) a >>= 1;
    while (b != 0) begin
      while ((b & 1) == 0) b >>= 1;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      b -= a;
    end
    return a << k;
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic out_beat_t fraction_result(in_beat_t f);
    out_beat_t r;
    logic signed [31:0] na, da, nb, db, n, d;
    logic [31:0] ma, mb, gd, sa, sb, g;
    logic signed [63:0] q;
    na = f.num_a; da = f.den_a; nb = f.num_b; db = f.den_b;
    r = '0;
    if (da == 0 || db == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (f.command == CMD_DIV && nb == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (f.command)
      CMD_MUL: begin
        n = na * nb; d = da * db;
      end
      CMD_DIV: begin
        n = na * db; d = da * nb;
      end
      default: begin
        ma = mag32(da); mb = mag32(db);
        gd = gcd32(ma, mb);
        sa = mb / gd; sb = ma / gd;
        if (da < 0) sa = -sa;
        if (db < 0) sb = -sb;
        n = (f.command == CMD_ADD) ? na * sa + nb * sb : na * sa - nb * sb;
        d = (ma / gd) * mb;
      end
    endcase
    if (n != 0 && d != 0) begin
      g = gcd32(mag32(n), mag32(d));
      if (g != 1) begin
        // 64-bit signed divide so -2^31 / g behaves like the wide reference
        q = 64'(n) / $signed({32'd0, g}); n = q[31:0];
        q = 64'(d) / $signed({32'd0, g}); d = q[31:0];
      end
    end
    r.res_num = n; r.res_den = d; r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [InWidth-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return InWidth'(int'($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? {1'b1, {(InWidth-1){1'b0}}}
                                     : {1'b0, {(InWidth-1){1'b1}}};
      2: return InWidth'(int'($urandom_range(0, 64)) - 32);
      default: return InWidth'($urandom());
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_beat_t f;
        f = op_queue.pop_front();
        in_valid <= 1'b1;
        in_data <= f;
        expected_q.push_back(fraction_result(f));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        out_beat_t e;
        e = expected_q.pop_front();
        if (e.res_num !== out_data.res_num || e.res_den !== out_data.res_den ||
            e.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                     e.res_num, e.res_den, e.status, out_data.res_num,
                     out_data.res_den, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_op(cmd_t c, int na, int da, int nb, int db);
    in_beat_t f;
    f.command = c;
    f.num_a = InWidth'(na); f.den_a = InWidth'(da);
    f.num_b = InWidth'(nb); f.den_b = InWidth'(db);
    op_queue.push_back(f);
  endtask

  task automatic wait_drained();
    while (op_queue.size() > 0 || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    in_beat_t f;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: each command, zero denominators, divide by zero, extremes
    add_op(CMD_MUL, 1, 2, 3, 4);
    add_op(CMD_DIV, 1, 2, 3, 4);
    add_op(CMD_ADD, 1, 6, 1, 4);
    add_op(CMD_SUB, 1, 6, 1, 4);
    add_op(CMD_ADD, 1, 0, 1, 4);
    add_op(CMD_MUL, 1, 3, 1, 0);
    add_op(CMD_DIV, 5, 0, 0, 3);
    add_op(CMD_DIV, 5, 7, 0, 3);
    add_op(CMD_MUL, 0, 5, 3, 7);
    add_op(CMD_SUB, 1, 2, 1, 2);
    add_op(CMD_MUL, -32768, -32768, -32768, -32768);
    add_op(CMD_MUL, -32768, 1, -32768, -1);
    add_op(CMD_DIV, 32767, -32768, -32768, 32767);
    add_op(CMD_ADD, 32767, -32768, -32768, 32767);
    add_op(CMD_SUB, -32768, 32767, 32767, -32768);
    add_op(CMD_ADD, -3, -4, 5, 6);
    add_op(CMD_SUB, 7, -9, -2, 9);
    add_op(CMD_MUL, 2, 3, 5, 7);
    add_op(CMD_DIV, -1, -1, -1, -1);
    add_op(CMD_ADD, 32767, 32767, 32767, 32767);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 45; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 45; end
        3: begin idle_pct = 6; stall_pct = 6; end
        4: begin idle_pct = 0; stall_pct = 0; hold_cycles = 1500; end
        default: ;
      endcase
      for (int i = 0; i < 140; i++) begin
        f.command = 2'($urandom_range(0, 3));
        f.num_a = rand_field(); f.den_a = rand_field();
        f.num_b = rand_field(); f.den_b = rand_field();
        op_queue.push_back(f);
      end
      wait_drained();
    end
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
